### rtl/dss_pkg.sv
// Package for the drive status supervisor: item types, drive state and
// verdict codes, register indexes and control word constants.
// No dependencies.
package dss_pkg;

  // Drive state as decoded from the status word
  typedef enum logic [3:0] {
    DS_NOT_READY     = 4'd0,
    DS_SW_ON_DISABLE = 4'd1,
    DS_READY         = 4'd2,
    DS_SWITCHED_ON   = 4'd3,
    DS_OP_ENABLED    = 4'd4,
    DS_QUICK_STOP    = 4'd5,
    DS_FAULT_REACT   = 4'd6,
    DS_FAULT         = 4'd7,
    DS_UNKNOWN       = 4'd8
  } drive_state_t;

  typedef enum logic [1:0] {
    VERDICT_FORWARD = 2'd0,
    VERDICT_WAIT    = 2'd1,
    VERDICT_ABORT   = 2'd2
  } verdict_t;

  // Configuration register indexes (byte address 4*index)
  typedef enum logic [1:0] {
    REG_ERROR_LIMIT    = 2'd0,
    REG_SETPOINT_CLEAR = 2'd1,
    REG_POSITION_MODE  = 2'd2
  } reg_index_t;

  localparam int unsigned PADDR_W = 4;
  localparam int unsigned PDATA_W = 32;

  localparam logic [15:0] ERR_NOT_COUNTED = 16'h7500;
  localparam logic [15:0] CMD_SHUTDOWN    = 16'h0006;
  localparam logic [15:0] CMD_ENABLE      = 16'h000F;
  localparam logic [15:0] CMD_FAULT_RESET = 16'h0080;
  localparam int unsigned SETPOINT_ACK_BIT = 12;

  localparam logic [7:0]        RST_ERROR_LIMIT    = 8'd10;
  localparam logic [15:0]       RST_SETPOINT_CLEAR = 16'h000F;
  localparam logic signed [7:0] RST_POSITION_MODE  = 8'sd1;

  typedef struct packed {
    logic [7:0]        error_limit;
    logic [15:0]       setpoint_clear_word;
    logic signed [7:0] position_mode_code;
  } cfg_t;

  // Classified feedback record passed from front to back
  typedef struct packed {
    logic [3:0]        motor_index;
    drive_state_t      drive_state;
    logic              setpoint_ack;
    logic signed [7:0] mode_shown;
    logic              err_nonzero;
    logic              err_counted;
  } front_item_t;

endpackage

### rtl/dss_if.sv
// Channel interfaces of the drive status supervisor: feedback records in,
// command results out. Depends on dss_pkg.
interface dss_feedback_if
  import dss_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [3:0]        motor_index;
  logic [15:0]       drive_status;
  logic [15:0]       drive_error;
  logic signed [7:0] mode_shown;

  modport source (
    output valid, motor_index, drive_status, drive_error, mode_shown,
    input  ready
  );
  modport sink (
    input  valid, motor_index, drive_status, drive_error, mode_shown,
    output ready
  );
endinterface

interface dss_command_if
  import dss_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [3:0]        motor_echo;
  verdict_t          verdict;
  drive_state_t      drive_state;
  logic              command_valid;
  logic [15:0]       command_word;
  logic              mode_valid;
  logic signed [7:0] mode_out;

  modport source (
    output valid, motor_echo, verdict, drive_state, command_valid, command_word,
           mode_valid, mode_out,
    input  ready
  );
  modport sink (
    input  valid, motor_echo, verdict, drive_state, command_valid, command_word,
           mode_valid, mode_out,
    output ready
  );
endinterface

### rtl/dss_cfg.sv
// APB register block of the drive status supervisor.
// Depends on dss_pkg.
module dss_cfg
  import dss_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output cfg_t               cfg
);

  cfg_t       regs;
  reg_index_t index;
  logic       wr_en;

  assign index  = reg_index_t'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = regs;

  // Write registers on the access phase
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.error_limit         <= RST_ERROR_LIMIT;
      regs.setpoint_clear_word <= RST_SETPOINT_CLEAR;
      regs.position_mode_code  <= RST_POSITION_MODE;
    end else if (wr_en) begin
      unique case (index)
        REG_ERROR_LIMIT:    regs.error_limit         <= pwdata[7:0];
        REG_SETPOINT_CLEAR: regs.setpoint_clear_word <= pwdata[15:0];
        REG_POSITION_MODE:  regs.position_mode_code  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (index)
      REG_ERROR_LIMIT:    prdata = {24'd0, regs.error_limit};
      REG_SETPOINT_CLEAR: prdata = {16'd0, regs.setpoint_clear_word};
      REG_POSITION_MODE:  prdata = {24'd0, regs.position_mode_code};
      default:            prdata = '0;
    endcase
  end

endmodule

### rtl/dss_front.sv
// Front end of the drive status supervisor: accepts feedback records,
// decodes the drive state and classifies the error code. Depends on dss_pkg.
module dss_front
  import dss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  dss_feedback_if.sink feedback,
  output logic        push,
  output front_item_t push_item,
  input  logic        push_ready
);

  logic        held;
  logic        held_next;
  front_item_t item;
  front_item_t decoded;
  logic        accept;

  assign feedback.ready = !held || push_ready;
  assign accept         = feedback.valid && feedback.ready;
  assign push           = held;
  assign push_item      = item;

  // Decode status word, first match wins
  always_comb begin
    logic [15:0] sw;
    sw = feedback.drive_status;
    if      ((sw & 16'h007F) == 16'h0037) decoded.drive_state = DS_OP_ENABLED;
    else if ((sw & 16'h004F) == 16'h0000) decoded.drive_state = DS_NOT_READY;
    else if ((sw & 16'h004F) == 16'h0040) decoded.drive_state = DS_SW_ON_DISABLE;
    else if ((sw & 16'h006F) == 16'h0021) decoded.drive_state = DS_READY;
    else if ((sw & 16'h007F) == 16'h0033) decoded.drive_state = DS_SWITCHED_ON;
    else if ((sw & 16'h006F) == 16'h0007) decoded.drive_state = DS_QUICK_STOP;
    else if ((sw & 16'h004F) == 16'h000F) decoded.drive_state = DS_FAULT_REACT;
    else if ((sw & 16'h004F) == 16'h0008) decoded.drive_state = DS_FAULT;
    else                                  decoded.drive_state = DS_UNKNOWN;
    decoded.motor_index  = feedback.motor_index;
    decoded.setpoint_ack = sw[SETPOINT_ACK_BIT];
    decoded.mode_shown   = feedback.mode_shown;
    decoded.err_nonzero  = (feedback.drive_error != 16'd0);
    decoded.err_counted  = (feedback.drive_error != 16'd0) &&
                           (feedback.drive_error != ERR_NOT_COUNTED);
  end

  // Hold one classified record until the queue takes it
  always_comb begin
    if (accept)    held_next = 1'b1;
    else if (push_ready) held_next = 1'b0;
    else           held_next = held;
  end

  always_ff @(posedge clk) begin
    if (rst) held <= 1'b0;
    else     held <= held_next;
  end

  always_ff @(posedge clk) begin
    if (accept) item <= decoded;
  end

endmodule

### rtl/dss_queue.sv
// Two-entry queue between front and back of the drive status supervisor.
// Depends on dss_pkg.
module dss_queue
  import dss_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  front_item_t push_item,
  output logic        push_ready,
  output logic        pop_valid,
  output front_item_t pop_item,
  input  logic        pop
);

  front_item_t entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_push;
  logic        do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = entries[rd_ptr];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= !wr_ptr;
      if (do_pop)  rd_ptr <= !rd_ptr;
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_item;
  end

endmodule

### rtl/dss_back.sv
// Back end of the drive status supervisor: counts drive errors, picks the
// verdict and control word, and holds the result. Depends on dss_pkg.
module dss_back
  import dss_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  cfg_t         cfg,
  input  logic         pop_valid,
  input  front_item_t  pop_item,
  output logic         pop,
  dss_command_if.source command
);

  logic [7:0]        fault_tally;
  logic [7:0]        fault_tally_next;
  logic              out_valid;
  logic              out_valid_next;
  verdict_t          verdict;
  logic              cmd_valid;
  logic [15:0]       cmd_word;
  logic              mode_valid;
  logic signed [7:0] mode_out;
  logic              err_abort;

  assign pop = pop_valid && (!out_valid || command.ready);

  // Saturating shared error count
  always_comb begin
    fault_tally_next = fault_tally;
    if (pop && pop_item.err_counted && fault_tally != 8'hFF)
      fault_tally_next = fault_tally + 8'd1;
    err_abort = pop_item.err_nonzero && (fault_tally_next >= cfg.error_limit);
  end

  // Choose verdict and command
  always_comb begin
    verdict    = VERDICT_WAIT;
    cmd_valid  = 1'b0;
    cmd_word   = 16'd0;
    mode_valid = 1'b0;
    mode_out   = 8'sd0;
    if (err_abort) begin
      verdict = VERDICT_ABORT;
    end else begin
      unique case (pop_item.drive_state)
        DS_SW_ON_DISABLE: begin
          cmd_valid = 1'b1;
          cmd_word  = CMD_SHUTDOWN;
        end
        DS_READY, DS_SWITCHED_ON: begin
          cmd_valid = 1'b1;
          cmd_word  = CMD_ENABLE;
        end
        DS_FAULT: begin
          cmd_valid = 1'b1;
          cmd_word  = CMD_FAULT_RESET;
        end
        DS_UNKNOWN: verdict = VERDICT_ABORT;
        DS_OP_ENABLED: begin
          if (pop_item.mode_shown == cfg.position_mode_code && pop_item.setpoint_ack) begin
            cmd_valid  = 1'b1;
            cmd_word   = cfg.setpoint_clear_word;
            mode_valid = 1'b1;
            mode_out   = cfg.position_mode_code;
          end else begin
            verdict = VERDICT_FORWARD;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pop)                out_valid_next = 1'b1;
    else if (command.ready) out_valid_next = 1'b0;
    else                    out_valid_next = out_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fault_tally <= 8'd0;
      out_valid   <= 1'b0;
    end else begin
      fault_tally <= fault_tally_next;
      out_valid   <= out_valid_next;
    end
  end

  // Load the result register
  always_ff @(posedge clk) begin
    if (pop) begin
      command.motor_echo    <= pop_item.motor_index;
      command.verdict       <= verdict;
      command.drive_state   <= pop_item.drive_state;
      command.command_valid <= cmd_valid;
      command.command_word  <= cmd_word;
      command.mode_valid    <= mode_valid;
      command.mode_out      <= mode_out;
    end
  end

  assign command.valid = out_valid;

endmodule

### rtl/drive_status_supervisor.sv
// Drive status supervisor top level: register block, front end, queue and
// back end. Depends on dss_pkg, dss_if, dss_cfg, dss_front, dss_queue, dss_back.
//
// Usage:
//   feedback: one record per transaction (motor index, status word, error
//     code, mode display), valid/ready handshake.
//   command:  one result per record, in order (motor echo, verdict, drive
//     state, control word and mode to write, with their valid flags).
//   APB port: error limit, setpoint clear word and position mode code at
//     byte addresses 0, 4 and 8; write them only while the block is idle.
// An accepted record passes through the front register, a queue entry and
// the result register before its result is valid. Throughput is one record
// per cycle while the receiver takes each result.
// Reset empties the pipeline, clears the error tally and loads the register
// defaults (limit 10, clear word 0x000F, position mode 1).
// When the receiver stalls, the result register holds, the two-entry queue
// and the front register fill, and feedback ready then drops.
module drive_status_supervisor
  import dss_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  dss_feedback_if.sink       feedback,
  dss_command_if.source      command,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  cfg_t        cfg;
  logic        push;
  front_item_t push_item;
  logic        push_ready;
  logic        pop_valid;
  front_item_t pop_item;
  logic        pop;

  dss_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dss_front u_front (
    .clk        (clk),
    .rst        (rst),
    .feedback   (feedback),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  dss_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_item   (pop_item),
    .pop        (pop)
  );

  dss_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_item  (pop_item),
    .pop       (pop),
    .command   (command)
  );

endmodule
